// ===== design/i2cm_pkg.sv =====
// Shared types and constants for the I2C register-transfer master.
// Holds the command record passed between front, queue and engine, and the result record.
// No dependencies.
package i2cm_pkg;

  // Default capacity of the write-data FIFO.
  localparam int FIFO_DEPTH_DEF = 16;

  // Depth of the command queue between front end and engine.
  localparam int Q_DEPTH = 2;

  // Operation codes as they arrive on the input channel.
  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_BEGIN = 2'd1,
    OP_PUSH  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Transaction kinds.
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_RWRITE = 2'd1;
  localparam logic [1:0] KIND_RREAD  = 2'd2;

  // Completion status codes.
  localparam logic [1:0] STS_OK   = 2'd0;
  localparam logic [1:0] STS_NACK = 2'd1;
  localparam logic [1:0] STS_REJ  = 2'd2;

  // One classified transaction from the input channel.
  typedef struct packed {
    op_t         op;
    logic        kind_bad;
    logic [1:0]  kind;
    logic [7:0]  dev_addr_write;
    logic [7:0]  dev_addr_read;
    logic [7:0]  reg_addr;
    logic [15:0] length;
    logic [7:0]  tx_byte;
    logic        sda_in;
  } cmd_t;

  // One result transaction.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       done;
    logic [1:0] status;
  } res_t;

endpackage

// ===== design/i2cm_front.sv =====
// Front end of the I2C master: decodes incoming transactions into commands.
// Depends on i2cm_pkg.
module i2cm_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_operation,
  input  logic [1:0]        in_kind,
  input  logic [7:0]        in_dev_addr_write,
  input  logic [7:0]        in_dev_addr_read,
  input  logic [7:0]        in_reg_addr,
  input  logic [15:0]       in_length,
  input  logic [7:0]        in_tx_byte,
  input  logic              in_sda_in,
  output logic              push,
  output i2cm_pkg::cmd_t    cmd,
  input  logic              q_ready
);
  import i2cm_pkg::*;

  op_t op_dec;

  always_comb begin
    unique case (in_operation)
      2'd0:    op_dec = OP_TICK;
      2'd1:    op_dec = OP_BEGIN;
      2'd2:    op_dec = OP_PUSH;
      default: op_dec = OP_NONE;
    endcase
  end

  assign in_ready = q_ready;
  assign push     = in_valid && q_ready;

  always_comb begin
    cmd.op             = op_dec;
    cmd.kind_bad       = (in_kind != KIND_WRITE) && (in_kind != KIND_RWRITE) &&
                         (in_kind != KIND_RREAD);
    cmd.kind           = in_kind;
    cmd.dev_addr_write = in_dev_addr_write;
    cmd.dev_addr_read  = in_dev_addr_read;
    cmd.reg_addr       = in_reg_addr;
    cmd.length         = in_length;
    cmd.tx_byte        = in_tx_byte;
    cmd.sda_in         = in_sda_in;
  end

endmodule

// ===== design/i2cm_queue.sv =====
// Short command queue that decouples the front end from the bus engine.
// Depends on i2cm_pkg.
module i2cm_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  i2cm_pkg::cmd_t push_cmd,
  output logic           q_ready,
  output logic           q_valid,
  output i2cm_pkg::cmd_t q_cmd,
  input  logic           pop
);
  import i2cm_pkg::*;

  localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  cmd_t             slot_r [Q_DEPTH];
  logic [QP_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  count_r, count_nxt;

  assign q_ready = count_r != QC_W'(Q_DEPTH);
  assign q_valid = count_r != '0;
  assign q_cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QP_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QP_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QP_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/i2cm_engine.sv =====
// Bus engine of the I2C master: sequencer, write FIFO, timing registers, result register.
// Depends on i2cm_pkg.
module i2cm_engine #(
  parameter int FIFO_DEPTH = i2cm_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [7:0]     cfg_wdata,
  input  logic           q_valid,
  input  i2cm_pkg::cmd_t q_cmd,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output i2cm_pkg::res_t out_res
);
  import i2cm_pkg::*;

  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
  localparam int IDX_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;

  localparam logic [1:0] CFG_SETUP = 2'd0;
  localparam logic [1:0] CFG_HIGH  = 2'd1;
  localparam logic [1:0] CFG_EDGE  = 2'd2;

  typedef enum logic [16:0] {
    PH_IDLE = 17'h00001,
    PH_STA  = 17'h00002,
    PH_STB  = 17'h00004,
    PH_STC  = 17'h00008,
    PH_WSU  = 17'h00010,
    PH_WHI  = 17'h00020,
    PH_WHO  = 17'h00040,
    PH_AHI  = 17'h00080,
    PH_ALO  = 17'h00100,
    PH_RHI  = 17'h00200,
    PH_RLO  = 17'h00400,
    PH_MSU  = 17'h00800,
    PH_MHI  = 17'h01000,
    PH_MHO  = 17'h02000,
    PH_SPA  = 17'h04000,
    PH_SPB  = 17'h08000,
    PH_SPC  = 17'h10000
  } phase_t;

  typedef enum logic [4:0] {
    SG_ADDRW = 5'b00001,
    SG_REG   = 5'b00010,
    SG_DATA  = 5'b00100,
    SG_ADDRR = 5'b01000,
    SG_READ  = 5'b10000
  } stage_t;

  logic [7:0]       setup_ticks_r, high_ticks_r, edge_ticks_r;
  phase_t           phase_r, phase_nxt;
  stage_t           stage_r, stage_nxt;
  logic [7:0]       tick_count_r, tick_count_nxt, tick_inc;
  logic [3:0]       bit_index_r, bit_index_nxt;
  logic [7:0]       shift_byte_r, shift_byte_nxt;
  logic [15:0]      bytes_left_r, bytes_left_nxt;
  logic [1:0]       txn_kind_r, txn_kind_nxt;
  logic [7:0]       addr_write_hold_r, addr_write_hold_nxt;
  logic [7:0]       addr_read_hold_r, addr_read_hold_nxt;
  logic [7:0]       reg_hold_r, reg_hold_nxt;
  logic [CNT_W-1:0] fifo_count_r, fifo_count_nxt;
  logic [CNT_W-1:0] fifo_head_r, fifo_head_nxt;
  logic             nack_seen_r, nack_seen_nxt;
  logic             mack_bit_r, mack_bit_nxt;
  logic [1:0]       line_levels_r, line_levels_nxt;
  logic [7:0]       fifo_mem [FIFO_DEPTH];
  logic [7:0]       rd_data_r;
  logic             mem_we;
  logic             out_valid_r;
  res_t             res, res_r;
  logic [1:0]       lv;

  // Line levels for a phase: bit 1 is SCL, bit 0 is SDA.
  function automatic logic [1:0] levels_of(phase_t p, logic b, logic m);
    logic [1:0] r;
    unique case (p) inside
      PH_STB, PH_SPB: r = 2'b10;
      PH_STC, PH_SPA: r = 2'b00;
      PH_WSU, PH_WHO: r = {1'b0, b};
      PH_WHI:         r = {1'b1, b};
      PH_ALO, PH_RLO: r = 2'b01;
      PH_MSU, PH_MHO: r = {1'b0, m};
      PH_MHI:         r = {1'b1, m};
      default:        r = 2'b11;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] span_of(phase_t p, logic [7:0] su, logic [7:0] hi,
                                         logic [7:0] ed);
    logic [7:0] d;
    unique case (p) inside
      PH_WSU, PH_WHO, PH_MSU, PH_MHO, PH_RLO: d = su;
      PH_WHI, PH_AHI, PH_RHI, PH_MHI:         d = hi;
      default:                                d = ed;
    endcase
    return (d == 8'd0) ? 8'd1 : d;
  endfunction

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    phase_nxt           = phase_r;
    stage_nxt           = stage_r;
    tick_count_nxt      = tick_count_r;
    bit_index_nxt       = bit_index_r;
    shift_byte_nxt      = shift_byte_r;
    bytes_left_nxt      = bytes_left_r;
    txn_kind_nxt        = txn_kind_r;
    addr_write_hold_nxt = addr_write_hold_r;
    addr_read_hold_nxt  = addr_read_hold_r;
    reg_hold_nxt        = reg_hold_r;
    fifo_count_nxt      = fifo_count_r;
    fifo_head_nxt       = fifo_head_r;
    nack_seen_nxt       = nack_seen_r;
    mack_bit_nxt        = mack_bit_r;
    line_levels_nxt     = line_levels_r;
    mem_we              = 1'b0;
    tick_inc            = tick_count_r + 8'd1;
    lv                  = line_levels_r;
    res                 = '0;

    if (pop) begin
      unique case (q_cmd.op)
        OP_BEGIN: begin
          if (phase_r != PH_IDLE || q_cmd.kind_bad ||
              (q_cmd.kind != KIND_RREAD && q_cmd.length > 16'(fifo_count_r))) begin
            res.done   = 1'b1;
            res.status = STS_REJ;
          end else begin
            txn_kind_nxt        = q_cmd.kind;
            addr_write_hold_nxt = q_cmd.dev_addr_write;
            addr_read_hold_nxt  = q_cmd.dev_addr_read;
            reg_hold_nxt        = q_cmd.reg_addr;
            bytes_left_nxt      = q_cmd.length;
            fifo_head_nxt       = '0;
            nack_seen_nxt       = 1'b0;
            stage_nxt           = SG_ADDRW;
            tick_count_nxt      = '0;
            phase_nxt           = PH_STA;
            line_levels_nxt     = levels_of(PH_STA, shift_byte_r[7], mack_bit_r);
            lv                  = line_levels_nxt;
          end
        end
        OP_PUSH: begin
          if (phase_r == PH_IDLE && fifo_count_r < CNT_W'(FIFO_DEPTH)) begin
            mem_we         = 1'b1;
            fifo_count_nxt = fifo_count_r + CNT_W'(1);
          end
        end
        OP_TICK: begin
          if (phase_r != PH_IDLE) begin
            lv = levels_of(phase_r, shift_byte_r[7], mack_bit_r);
            tick_count_nxt = tick_inc;
            if (tick_inc >= span_of(phase_r, setup_ticks_r, high_ticks_r, edge_ticks_r)) begin
              tick_count_nxt = '0;
              unique case (phase_r)
                PH_STA: phase_nxt = PH_STB;
                PH_STB: phase_nxt = PH_STC;
                PH_STC: begin
                  shift_byte_nxt = (stage_r == SG_ADDRR) ? addr_read_hold_r
                                                         : addr_write_hold_r;
                  bit_index_nxt  = '0;
                  phase_nxt      = PH_WSU;
                end
                PH_WSU: phase_nxt = PH_WHI;
                PH_WHI: phase_nxt = PH_WHO;
                PH_WHO: begin
                  shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
                  bit_index_nxt  = bit_index_r + 4'd1;
                  phase_nxt      = (bit_index_nxt >= 4'd8) ? PH_AHI : PH_WSU;
                end
                PH_AHI: begin
                  nack_seen_nxt = q_cmd.sda_in;
                  phase_nxt     = PH_ALO;
                end
                PH_ALO: begin
                  if (nack_seen_r) begin
                    phase_nxt = PH_SPA;
                  end else if (stage_r == SG_ADDRW && txn_kind_r != KIND_WRITE) begin
                    stage_nxt      = SG_REG;
                    shift_byte_nxt = reg_hold_r;
                    bit_index_nxt  = '0;
                    phase_nxt      = PH_WSU;
                  end else if (stage_r == SG_REG && txn_kind_r == KIND_RREAD) begin
                    stage_nxt = SG_ADDRR;
                    phase_nxt = PH_STA;
                  end else if (stage_r == SG_ADDRR) begin
                    stage_nxt = SG_READ;
                    if (bytes_left_r == '0) begin
                      phase_nxt = PH_SPA;
                    end else begin
                      bytes_left_nxt = bytes_left_r - 16'd1;
                      shift_byte_nxt = '0;
                      bit_index_nxt  = '0;
                      phase_nxt      = PH_RHI;
                    end
                  end else begin
                    // Next data byte from the FIFO, or stop once all are sent.
                    stage_nxt = SG_DATA;
                    if (bytes_left_r == '0) begin
                      phase_nxt = PH_SPA;
                    end else begin
                      bytes_left_nxt = bytes_left_r - 16'd1;
                      shift_byte_nxt = rd_data_r;
                      bit_index_nxt  = '0;
                      phase_nxt      = PH_WSU;
                      fifo_head_nxt  = fifo_head_r + CNT_W'(1);
                    end
                  end
                end
                PH_RHI: begin
                  shift_byte_nxt = {shift_byte_r[6:0], q_cmd.sda_in};
                  bit_index_nxt  = bit_index_r + 4'd1;
                  if (bit_index_nxt >= 4'd8) begin
                    res.rx_valid = 1'b1;
                    res.rx_byte  = shift_byte_nxt;
                  end
                  phase_nxt = PH_RLO;
                end
                PH_RLO: begin
                  if (bit_index_r < 4'd8) begin
                    phase_nxt = PH_RHI;
                  end else begin
                    mack_bit_nxt = (bytes_left_r == '0);
                    phase_nxt    = PH_MSU;
                  end
                end
                PH_MSU: phase_nxt = PH_MHI;
                PH_MHI: phase_nxt = PH_MHO;
                PH_MHO: begin
                  if (bytes_left_r == '0) begin
                    phase_nxt = PH_SPA;
                  end else begin
                    bytes_left_nxt = bytes_left_r - 16'd1;
                    shift_byte_nxt = '0;
                    bit_index_nxt  = '0;
                    phase_nxt      = PH_RHI;
                  end
                end
                PH_SPA: phase_nxt = PH_SPB;
                PH_SPB: phase_nxt = PH_SPC;
                PH_SPC: begin
                  res.done   = 1'b1;
                  res.status = nack_seen_r ? STS_NACK : STS_OK;
                  if (txn_kind_r != KIND_RREAD) begin
                    fifo_count_nxt = '0;
                  end
                  phase_nxt = PH_IDLE;
                end
                default: ;
              endcase
              line_levels_nxt = levels_of(phase_nxt, shift_byte_nxt[7], mack_bit_nxt);
            end
          end
        end
        default: ;
      endcase
    end

    res.scl  = lv[1];
    res.sda  = lv[0];
    res.busy = phase_nxt != PH_IDLE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_ticks_r     <= 8'd2;
      high_ticks_r      <= 8'd3;
      edge_ticks_r      <= 8'd3;
      phase_r           <= PH_IDLE;
      stage_r           <= SG_ADDRW;
      tick_count_r      <= '0;
      bit_index_r       <= '0;
      shift_byte_r      <= '0;
      bytes_left_r      <= '0;
      txn_kind_r        <= '0;
      addr_write_hold_r <= '0;
      addr_read_hold_r  <= '0;
      reg_hold_r        <= '0;
      fifo_count_r      <= '0;
      fifo_head_r       <= '0;
      nack_seen_r       <= 1'b0;
      mack_bit_r        <= 1'b0;
      line_levels_r     <= 2'b11;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SETUP: setup_ticks_r <= cfg_wdata;
          CFG_HIGH:  high_ticks_r  <= cfg_wdata;
          CFG_EDGE:  edge_ticks_r  <= cfg_wdata;
          default: ;
        endcase
      end
      phase_r           <= phase_nxt;
      stage_r           <= stage_nxt;
      tick_count_r      <= tick_count_nxt;
      bit_index_r       <= bit_index_nxt;
      shift_byte_r      <= shift_byte_nxt;
      bytes_left_r      <= bytes_left_nxt;
      txn_kind_r        <= txn_kind_nxt;
      addr_write_hold_r <= addr_write_hold_nxt;
      addr_read_hold_r  <= addr_read_hold_nxt;
      reg_hold_r        <= reg_hold_nxt;
      fifo_count_r      <= fifo_count_nxt;
      fifo_head_r       <= fifo_head_nxt;
      nack_seen_r       <= nack_seen_nxt;
      mack_bit_r        <= mack_bit_nxt;
      line_levels_r     <= line_levels_nxt;
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res;
    end
  end

  // Write FIFO; prefetch the entry at the next head so a byte is ready on load.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      fifo_mem[fifo_count_r[IDX_W-1:0]] <= q_cmd.tx_byte;
    end
    rd_data_r <= fifo_mem[fifo_head_nxt[IDX_W-1:0]];
  end

  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_count_r <= CNT_W'(FIFO_DEPTH))
    else $error("write FIFO count above depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE && txn_kind_r != KIND_RREAD) |-> fifo_head_r <= fifo_count_r)
    else $error("FIFO read head passed fill count");

  a_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_IDLE) ##1 (phase_r != PH_IDLE) |-> $stable(fifo_count_r))
    else $error("FIFO count changed during a bus transaction");

  a_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.done || res_r.status != STS_OK)) |->
      (res_r.done && !res_r.rx_valid))
    else $error("status without done, or done with read data");

endmodule

// ===== design/i2c_master_register_transfer.sv =====
// I2C master for plain writes, register writes and register reads, advanced one tick per tick transaction.
// Each accepted transaction passes through the queue, then the engine result register, before
// its result appears. Throughput: one transaction per cycle while out_ready does not stall the
// result channel. Reset (rst_n low, synchronous) idles the bus with both lines high,
// empties the write FIFO and restores the timing registers to 2/3/3; FIFO contents stay
// undefined, no clearing pass.
// Depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_engine.
module i2c_master_register_transfer #(
  parameter int FIFO_DEPTH = i2cm_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [1:0]  in_kind,
  input  logic [7:0]  in_dev_addr_write,
  input  logic [7:0]  in_dev_addr_read,
  input  logic [7:0]  in_reg_addr,
  input  logic [15:0] in_length,
  input  logic [7:0]  in_tx_byte,
  input  logic        in_sda_in,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_scl,
  output logic        out_sda,
  output logic        out_busy_res,
  output logic        out_rx_valid,
  output logic [7:0]  out_rx_byte,
  output logic        out_done_res,
  output logic [1:0]  out_status
);
  import i2cm_pkg::*;

  // Front end -> queue
  logic push;
  logic q_ready;
  cmd_t push_cmd;

  // Queue -> engine
  logic q_valid;
  logic pop;
  cmd_t q_cmd;

  res_t res;

  // Decode each input transaction into a command.
  i2cm_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_kind           (in_kind),
    .in_dev_addr_write (in_dev_addr_write),
    .in_dev_addr_read  (in_dev_addr_read),
    .in_reg_addr       (in_reg_addr),
    .in_length         (in_length),
    .in_tx_byte        (in_tx_byte),
    .in_sda_in         (in_sda_in),
    .push              (push),
    .cmd               (push_cmd),
    .q_ready           (q_ready)
  );

  // Buffer up to Q_DEPTH commands so the input side can still accept while results stall, until the queue is full.
  i2cm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .q_ready  (q_ready),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .pop      (pop)
  );

  // Advance the bus sequencer one command per cycle unless results stall; hold results in its output register.
  i2cm_engine #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  // Break the result record out onto the ports.
  assign out_scl      = res.scl;
  assign out_sda      = res.sda;
  assign out_busy_res = res.busy;
  assign out_rx_valid = res.rx_valid;
  assign out_rx_byte  = res.rx_byte;
  assign out_done_res = res.done;
  assign out_status   = res.status;

endmodule
